### src/hcc_pkg.sv
// Shared constants, types and helpers for the hex colour command parser.
package hcc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned NUM_NIB = 6;

	localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'd0;
	localparam logic [BYTE_W-1:0] CHAR_LF   = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_CR   = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_HASH = 8'h23;
	localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_F    = 8'h46;

	// '#' plus six digits
	localparam logic [COUNT_W-1:0] COLOR_LINE_LEN = 8'd7;

	typedef struct packed {
		logic              ok;
		logic [NIB_W-1:0]  value;
	} hex_digit_t;

	// Decode one uppercase hex digit.
	function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_digit_t d;
		logic [BYTE_W-1:0] diff;
		d = '{ok: 1'b0, value: '0};
		if (c >= CHAR_0 && c <= CHAR_9) begin
			diff = c - CHAR_0;
			d = '{ok: 1'b1, value: diff[NIB_W-1:0]};
		end else if (c >= CHAR_A && c <= CHAR_F) begin
			diff = c - CHAR_A + 8'd10;
			d = '{ok: 1'b1, value: diff[NIB_W-1:0]};
		end
		return d;
	endfunction

endpackage

### src/hcc_if.sv
// Valid/ready channel interfaces for received and transmitted bytes.
interface hcc_rx_if
	import hcc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcc_tx_if
	import hcc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] tx_byte;
	logic              last;
	logic              color_set;
	logic [BYTE_W-1:0] red;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] blue;
	logic              red_on;
	logic              green_on;
	logic              blue_on;

	modport source (
		output valid, output tx_byte, output last, output color_set,
		output red, output green, output blue,
		output red_on, output green_on, output blue_on,
		input ready
	);
	modport sink (
		input valid, input tx_byte, input last, input color_set,
		input red, input green, input blue,
		input red_on, input green_on, input blue_on,
		output ready
	);
endinterface

### src/hex_color_command_parser.sv
// Serial colour command parser: echo, line collection and RGB duty decode.
//
//  channel | dir | payload                                   | per request
//  --------+-----+-------------------------------------------+--------------------------
//  rx      | in  | rx_byte                                   | one received byte
//  tx      | out | tx_byte, last, color_set, red/green/blue, | one byte; three after CR
//          |     | red_on/green_on/blue_on                   |
//
// A byte sits in the input register and leaves one result a cycle into the output
// register while tx does not stall: one result per ordinary byte, three for a carriage
// return (CR, CR, LF from the step sequencer). A new byte is taken in the cycle its
// predecessor issues its last result. Reset clears the line state to an empty valid line.
// The output register holds under tx stall; the input register then holds too.
module hex_color_command_parser
	import hcc_pkg::*;
#(
	parameter int unsigned LINE_DEPTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	hcc_rx_if.sink    rx,
	hcc_tx_if.source  tx
);

	typedef enum logic [2:0] {
		STEP_ECHO = 3'b001,
		STEP_CR   = 3'b010,
		STEP_LF   = 3'b100
	} step_t;

	localparam logic [COUNT_W-1:0] DEPTH_MAX = COUNT_W'(LINE_DEPTH);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	step_t             step_q;

	logic [COUNT_W-1:0] count_q;
	logic [NIB_W-1:0]   nib_q [NUM_NIB];
	logic               ok_q;

	logic              tx_valid_q;
	logic [BYTE_W-1:0] tx_byte_q;
	logic              last_q;
	logic              color_set_q;
	logic [BYTE_W-1:0] red_q;
	logic [BYTE_W-1:0] green_q;
	logic [BYTE_W-1:0] blue_q;

	logic              out_free;
	logic              issue;
	logic              is_cr;
	logic              is_nul;
	logic              final_item;
	logic              pop;
	logic              color_ok;
	logic [BYTE_W-1:0] next_tx;
	logic [BYTE_W-1:0] red_c;
	logic [BYTE_W-1:0] green_c;
	logic [BYTE_W-1:0] blue_c;
	hex_digit_t        digit;

	always_comb begin
		out_free   = !tx_valid_q || tx.ready;
		issue      = valid_s1 && out_free;
		is_cr      = (byte_s1 == CHAR_CR);
		is_nul     = (byte_s1 == CHAR_NUL);
		final_item = !is_cr || (step_q == STEP_LF);
		pop        = issue && final_item;
		color_ok   = (count_q == COLOR_LINE_LEN) && ok_q;
		red_c      = {nib_q[0], nib_q[1]};
		green_c    = {nib_q[2], nib_q[3]};
		blue_c     = {nib_q[4], nib_q[5]};
		digit      = hex_decode(byte_s1);
		next_tx    = byte_s1;
		if (is_cr && step_q == STEP_LF) begin
			next_tx = CHAR_LF;
		end
	end

	assign rx.ready = !valid_s1 || pop;

	// input register and CR step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_q   <= STEP_ECHO;
		end else begin
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (pop) begin
				valid_s1 <= 1'b0;
			end
			if (issue && is_cr) begin
				case (step_q)
					STEP_ECHO: step_q <= STEP_CR;
					STEP_CR:   step_q <= STEP_LF;
					STEP_LF:   step_q <= STEP_ECHO;
					default:   step_q <= STEP_ECHO;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// line state: advance when a non-NUL byte retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ok_q    <= 1'b1;
			for (int i = 0; i < NUM_NIB; i++) begin
				nib_q[i] <= '0;
			end
		end else if (pop && !is_nul) begin
			if (is_cr) begin
				count_q <= '0;
				ok_q    <= 1'b1;
				for (int i = 0; i < NUM_NIB; i++) begin
					nib_q[i] <= '0;
				end
			end else begin
				if (count_q == '0) begin
					if (byte_s1 != CHAR_HASH) begin
						ok_q <= 1'b0;
					end
				end else if (count_q < COLOR_LINE_LEN) begin
					if (!digit.ok) begin
						ok_q <= 1'b0;
					end
					for (int i = 0; i < NUM_NIB; i++) begin
						if (digit.ok && count_q == COUNT_W'(i + 1)) begin
							nib_q[i] <= digit.value;
						end
					end
				end else begin
					ok_q <= 1'b0;
				end
				if (count_q < DEPTH_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (issue) begin
			tx_valid_q <= 1'b1;
		end else if (tx.ready) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tx_byte_q <= next_tx;
			last_q    <= final_item;
			if (is_cr && step_q == STEP_LF && color_ok) begin
				color_set_q <= 1'b1;
				red_q       <= red_c;
				green_q     <= green_c;
				blue_q      <= blue_c;
			end else begin
				color_set_q <= 1'b0;
				red_q       <= '0;
				green_q     <= '0;
				blue_q      <= '0;
			end
		end
	end

	assign tx.valid     = tx_valid_q;
	assign tx.tx_byte   = tx_byte_q;
	assign tx.last      = last_q;
	assign tx.color_set = color_set_q;
	assign tx.red       = red_q;
	assign tx.green     = green_q;
	assign tx.blue      = blue_q;
	assign tx.red_on    = (red_q != '0);
	assign tx.green_on  = (green_q != '0);
	assign tx.blue_on   = (blue_q != '0);

endmodule

### tb/sv/tb_hex_color_command_parser.sv
// Testbench for the hex colour command parser: directed table, random lines, scoreboard.
module tb_hex_color_command_parser;
	import hcc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINE_DEPTH     = 128;
	localparam int unsigned TOTAL_BYTES    = 470;
	localparam int unsigned QUIET_BYTES    = 390;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              last;
		logic              color_set;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic              red_on;
		logic              green_on;
		logic              blue_on;
	} tx_item_t;

	typedef tx_item_t tx_burst_t [3];

	// One byte of the directed table; typed rows carry their own expected colour.
	typedef struct {
		logic [BYTE_W-1:0] rx;
		bit                typed;
		bit                color_set;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} stim_row_t;

	logic clk;
	logic arst_n;

	hcc_rx_if rx_ch ();
	hcc_tx_if tx_ch ();

	hex_color_command_parser #(
		.LINE_DEPTH(LINE_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Line state of the predictor
	logic [COUNT_W-1:0] line_len;
	logic [NIB_W-1:0]   line_digits [NUM_NIB];
	logic               line_good;

	tx_item_t  tx_expected [$];
	stim_row_t offered_row;
	int unsigned bytes_sent;
	int unsigned fail_count;
	int unsigned quiet_cycles;
	bit rx_gaps_on;
	bit tx_stalls_on;
	bit hold_tx_request;

	stim_row_t directed_rows [0:24] = '{
		'{CHAR_NUL,     1, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_CR,      1, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_HASH,    1, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_F,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_NUL,     1, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_F,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_F,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_F,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_F,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_F,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_CR,      1, 1, 8'hFF, 8'hFF, 8'hFF},
		'{CHAR_HASH,    1, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_0,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_0,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_0,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_0,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_0,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_0,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_CR,      1, 1, 8'h00, 8'h00, 8'h00},
		'{CHAR_HASH,    0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_9,       0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_LOWER_A, 0, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_A,       0, 0, 8'h00, 8'h00, 8'h00},
		'{8'hFF,        1, 0, 8'h00, 8'h00, 8'h00},
		'{CHAR_CR,      1, 0, 8'h00, 8'h00, 8'h00}
	};

	function automatic tx_item_t color_line_item(input logic [BYTE_W-1:0] r,
			input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] b);
		tx_item_t it;
		it = '0;
		it.tx_byte   = CHAR_LF;
		it.last      = 1'b1;
		it.color_set = 1'b1;
		it.red       = r;
		it.green     = g;
		it.blue      = b;
		it.red_on    = (r != 0);
		it.green_on  = (g != 0);
		it.blue_on   = (b != 0);
		return it;
	endfunction

	function automatic void clear_line_state();
		line_len  = '0;
		line_good = 1'b1;
		foreach (line_digits[i])
			line_digits[i] = '0;
	endfunction

	// Advance the line state by one byte and return the transmit bytes it causes.
	function automatic int parse_rx_byte(input logic [BYTE_W-1:0] c, output tx_burst_t res);
		logic [COUNT_W-1:0] pos;
		logic [NIB_W-1:0]   nib;
		bit                 is_hex;
		pos = line_len;
		res[0] = '0;
		res[1] = '0;
		res[2] = '0;
		if (c == CHAR_NUL) begin
			res[0].last = 1'b1;
			return 1;
		end
		if (c == CHAR_CR) begin
			res[0].tx_byte = CHAR_CR;
			res[1].tx_byte = CHAR_CR;
			res[2].tx_byte = CHAR_LF;
			res[2].last    = 1'b1;
			if (pos == COLOR_LINE_LEN && line_good)
				res[2] = color_line_item({line_digits[0], line_digits[1]},
					{line_digits[2], line_digits[3]}, {line_digits[4], line_digits[5]});
			clear_line_state();
			return 3;
		end
		res[0].tx_byte = c;
		res[0].last    = 1'b1;
		is_hex = 1'b1;
		nib    = '0;
		if (c >= CHAR_0 && c <= CHAR_9)
			nib = NIB_W'(c - CHAR_0);
		else if (c >= CHAR_A && c <= CHAR_F)
			nib = NIB_W'(c - CHAR_A + 8'd10);
		else
			is_hex = 1'b0;
		if (pos == 0) begin
			if (c != CHAR_HASH)
				line_good = 1'b0;
		end else if (pos <= NUM_NIB) begin
			if (is_hex)
				line_digits[pos - 1] = nib;
			else
				line_good = 1'b0;
		end else begin
			line_good = 1'b0;
		end
		if (line_len < LINE_DEPTH)
			line_len = line_len + 1'b1;
		return 1;
	endfunction

	function automatic int typed_burst(input stim_row_t row, output tx_burst_t res);
		res[0] = '0;
		res[1] = '0;
		res[2] = '0;
		if (row.rx != CHAR_CR) begin
			res[0].tx_byte = row.rx;
			res[0].last    = 1'b1;
			return 1;
		end
		res[0].tx_byte = CHAR_CR;
		res[1].tx_byte = CHAR_CR;
		res[2].tx_byte = CHAR_LF;
		res[2].last    = 1'b1;
		if (row.color_set)
			res[2] = color_line_item(row.red, row.green, row.blue);
		return 3;
	endfunction

	function automatic bit tx_item_differs(input tx_item_t want, input tx_item_t got);
		bit bad;
		bad = 1'b0;
		if (got.tx_byte !== want.tx_byte) begin
			$error("tx_byte mismatch: expected %0h, got %0h", want.tx_byte, got.tx_byte);
			bad = 1'b1;
		end
		if (got.last !== want.last) begin
			$error("last mismatch: expected %0h, got %0h", want.last, got.last);
			bad = 1'b1;
		end
		if (got.color_set !== want.color_set) begin
			$error("color_set mismatch: expected %0h, got %0h", want.color_set, got.color_set);
			bad = 1'b1;
		end
		if (got.red !== want.red) begin
			$error("red mismatch: expected %0h, got %0h", want.red, got.red);
			bad = 1'b1;
		end
		if (got.green !== want.green) begin
			$error("green mismatch: expected %0h, got %0h", want.green, got.green);
			bad = 1'b1;
		end
		if (got.blue !== want.blue) begin
			$error("blue mismatch: expected %0h, got %0h", want.blue, got.blue);
			bad = 1'b1;
		end
		if (got.red_on !== want.red_on) begin
			$error("red_on mismatch: expected %0h, got %0h", want.red_on, got.red_on);
			bad = 1'b1;
		end
		if (got.green_on !== want.green_on) begin
			$error("green_on mismatch: expected %0h, got %0h", want.green_on, got.green_on);
			bad = 1'b1;
		end
		if (got.blue_on !== want.blue_on) begin
			$error("blue_on mismatch: expected %0h, got %0h", want.blue_on, got.blue_on);
			bad = 1'b1;
		end
		return bad;
	endfunction

	// Accepted requests feed the predictor; accepted results are checked in order.
	always @(posedge clk) begin : scoreboard
		tx_burst_t burst;
		tx_item_t  got;
		tx_item_t  want;
		int        n;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rx_ch.valid && rx_ch.ready) begin
				moved = 1'b1;
				n = parse_rx_byte(rx_ch.rx_byte, burst);
				if (offered_row.typed)
					n = typed_burst(offered_row, burst);
				for (int k = 0; k < n; k++)
					tx_expected.push_back(burst[k]);
			end
			if (tx_ch.valid && tx_ch.ready) begin
				moved = 1'b1;
				got = '{tx_ch.tx_byte, tx_ch.last, tx_ch.color_set, tx_ch.red, tx_ch.green,
					tx_ch.blue, tx_ch.red_on, tx_ch.green_on, tx_ch.blue_on};
				if (tx_expected.size() == 0) begin
					$error("unexpected result: tx_byte %0h", got.tx_byte);
					fail_count++;
				end else begin
					want = tx_expected.pop_front();
					if (tx_item_differs(want, got))
						fail_count++;
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("hex_color_command_parser test failed");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin : tx_ready_driver
		int burst_len;
		tx_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_tx_request) begin
				tx_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_tx_request = 1'b0;
			end else if (tx_stalls_on && $urandom_range(0, 5) == 0) begin
				burst_len = $urandom_range(1, 16);
				tx_ch.ready <= 1'b0;
				repeat (burst_len - 1) @(negedge clk);
			end else begin
				tx_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one request, after an optional gap, and hold it until accepted.
	task automatic push_request(input stim_row_t row);
		int gap;
		if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			rx_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		offered_row = row;
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= row.rx;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		stim_row_t row;
		row = '{b, 0, 0, 8'h00, 8'h00, 8'h00};
		push_request(row);
	endtask

	function automatic logic [BYTE_W-1:0] hex_digit_char(input int unsigned v);
		return (v < 10) ? CHAR_0 + BYTE_W'(v) : CHAR_A + BYTE_W'(v - 10);
	endfunction

	function automatic logic [BYTE_W-1:0] text_byte();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(1, 255)); while (b == CHAR_CR);
		return b;
	endfunction

	// '#' and six digits, optionally broken in one way, maybe with a zero byte inside.
	task automatic send_color_line(input bit broken);
		logic [BYTE_W-1:0] chars [$];
		chars.push_back(CHAR_HASH);
		repeat (NUM_NIB) chars.push_back(hex_digit_char($urandom_range(0, 15)));
		if (broken) begin
			case ($urandom_range(0, 3))
				0: chars[$urandom_range(0, NUM_NIB)] = text_byte();
				1: chars[$urandom_range(1, NUM_NIB)] = CHAR_LOWER_A + BYTE_W'($urandom_range(0, 5));
				2: chars.delete($urandom_range(0, NUM_NIB));
				default: chars.push_back(hex_digit_char($urandom_range(0, 15)));
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			chars.insert($urandom_range(0, chars.size()), CHAR_NUL);
		foreach (chars[i])
			push_byte(chars[i]);
		push_byte(CHAR_CR);
	endtask

	initial begin : stimulus
		int  pick;
		bit  held;
		bit  paused;
		bit  long_done;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		offered_row   = '{CHAR_NUL, 0, 0, 8'h00, 8'h00, 8'h00};
		bytes_sent    = 0;
		fail_count    = 0;
		quiet_cycles  = 0;
		rx_gaps_on    = 1'b1;
		tx_stalls_on  = 1'b1;
		hold_tx_request = 1'b0;
		held      = 1'b0;
		paused    = 1'b0;
		long_done = 1'b0;
		clear_line_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			push_request(directed_rows[i]);

		while (bytes_sent < TOTAL_BYTES) begin
			if (!held && bytes_sent >= 80) begin
				hold_tx_request = 1'b1;
				held = 1'b1;
			end
			if (!long_done && bytes_sent >= 140) begin
				// overrun the line buffer so the count saturates
				push_byte(CHAR_HASH);
				repeat (LINE_DEPTH + 12) push_byte(text_byte());
				push_byte(CHAR_CR);
				long_done = 1'b1;
			end
			if (!paused && bytes_sent >= 330) begin
				// drop the request line while the results drain
				@(negedge clk);
				rx_ch.valid <= 1'b0;
				while (tx_expected.size() != 0) @(posedge clk);
				paused = 1'b1;
			end
			if (bytes_sent >= QUIET_BYTES) begin
				rx_gaps_on   = 1'b0;
				tx_stalls_on = 1'b0;
			end
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				send_color_line(1'b0);
			end else if (pick < 9) begin
				send_color_line(1'b1);
			end else begin
				repeat ($urandom_range(0, 10)) push_byte(BYTE_W'($urandom_range(0, 255)));
				push_byte(CHAR_CR);
			end
		end

		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (tx_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("hex_color_command_parser test passed");
		else
			$display("hex_color_command_parser test failed");
		$finish;
	end

endmodule
